FILE: sv/mdc_pkg.sv
`timescale 1ns / 1ps
// Package for the multiclass detection confirmer.
// Register indexes, reset values and field widths; no dependencies.
package mdc_pkg;

    localparam int unsigned NUM_CLASSES = 4;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned SEEN_W    = 3;
    localparam int unsigned REACT_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;
    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 8;

    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    typedef logic [CFG_DAT_W-1:0] t_cfg_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_LIMIT   = 2'd0,
        REG_CONFIRM_LEVEL = 2'd1,
        REG_RELEASE_LEVEL = 2'd2
    } t_cfg_reg;

    localparam t_count COUNT_LIMIT_RST   = 8'd60;
    localparam t_count CONFIRM_LEVEL_RST = 8'd40;
    localparam t_count RELEASE_LEVEL_RST = 8'd10;

endpackage

FILE: sv/multiclass_detection_confirmer_unit.sv
`timescale 1ns / 1ps
// Top level of the multiclass detection confirmer: evidence counters,
// confirm flags, reaction queue and output register. Depends on mdc_pkg.
//
//  channel | direction | handshake               | payload
//  s       | in        | i_s_tvalid/o_s_tready   | tdata[2:0] seen_class
//  m       | out       | o_m_tvalid/i_m_tready   | tdata[1:0] react_class, tlast last_of_run
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data[7:0]
//
// A frame is taken and the counters, flags and its reaction mask are registered
// together. Frames with no reaction follow each other every cycle.
// A frame with k reactions gives k beats, one per cycle while i_m_tready is high;
// the next frame is taken in the cycle the last of them leaves the pending mask.
// Synchronous active-low reset restores the default levels and clears all
// counters, flags and pending beats. Config writes are always ready.
module multiclass_detection_confirmer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [mdc_pkg::S_DATA_W-1:0] i_s_tdata,  // [2:0] seen_class
    // master stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [mdc_pkg::M_DATA_W-1:0] o_m_tdata,  // [1:0] react_class
    output logic                       o_m_tlast,    // last_of_run
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  mdc_pkg::t_cfg_index        i_cfg_index,
    input  mdc_pkg::t_cfg_data         i_cfg_data
);
    import mdc_pkg::*;

    t_count r_count_limit, r_confirm_level, r_release_level;

    t_count                 r_cnt [NUM_CLASSES];
    t_count                 n_cnt [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_conf, n_conf;
    logic [NUM_CLASSES-1:0] r_mask, n_mask;
    logic [NUM_CLASSES-1:0] n_react;

    logic                   r_out_valid;
    logic [REACT_W-1:0]     r_out_class;
    logic                   r_out_last;

    logic                   s_acc;
    logic                   load_out;
    logic [NUM_CLASSES-1:0] low_bit, mask_rest, mask_after;
    logic [REACT_W-1:0]     low_class;
    logic [SEEN_W-1:0]      seen;
    logic [NUM_CLASSES-1:0] conf_set;
    t_count                 lead_val;
    logic [NUM_CLASSES-1:0] lead_hot;
    logic [CNT_W:0]         up;

    assign seen        = i_s_tdata[SEEN_W-1:0];
    assign o_cfg_ready = 1'b1;

    // drain the pending mask lowest class first
    assign low_bit   = r_mask & (~r_mask + 1'b1);
    assign mask_rest = r_mask & ~low_bit;
    assign load_out  = (r_mask != '0) && (!r_out_valid || i_m_tready);
    assign mask_after = load_out ? mask_rest : r_mask;
    assign o_s_tready = (mask_after == '0);
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        low_class = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (low_bit[i]) begin
                low_class = REACT_W'(i);
            end
        end
    end

    // counter update, leader search, confirm and release
    always_comb begin
        up       = '0;
        lead_val = '0;
        lead_hot = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (32'(seen) == i) begin
                up       = {1'b0, r_cnt[i]} + 1'b1;
                n_cnt[i] = (up < {1'b0, r_count_limit}) ? up[CNT_W-1:0] : r_count_limit;
            end else begin
                n_cnt[i] = (r_cnt[i] != '0) ? r_cnt[i] - 1'b1 : '0;
            end
        end
        // strict compare keeps the lowest index on ties; zero never leads
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (n_cnt[i] > lead_val) begin
                lead_val = n_cnt[i];
                lead_hot = '0;
                lead_hot[i] = 1'b1;
            end
        end
        conf_set = (lead_val >= r_confirm_level) ? lead_hot : '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            n_react[i] = (r_conf[i] || conf_set[i]) && (n_cnt[i] <= r_release_level);
        end
        n_conf = (r_conf | conf_set) & ~n_react;
        n_mask = s_acc ? n_react : mask_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit   <= COUNT_LIMIT_RST;
            r_confirm_level <= CONFIRM_LEVEL_RST;
            r_release_level <= RELEASE_LEVEL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COUNT_LIMIT:   r_count_limit   <= i_cfg_data;
                REG_CONFIRM_LEVEL: r_confirm_level <= i_cfg_data;
                REG_RELEASE_LEVEL: r_release_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_cnt[i] <= '0;
            end
            r_conf      <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_cnt  <= n_cnt;
                r_conf <= n_conf;
            end
            r_mask <= n_mask;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_class <= low_class;
            r_out_last  <= (mask_rest == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W - REACT_W){1'b0}}, r_out_class};
    assign o_m_tlast  = r_out_last;

    // a class waiting to react is never confirmed at the same time
    a_mask_conf_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask & r_conf) == '0)
        else $error("pending reaction on a confirmed class");

    // a beat that is not last always has more of its run queued
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_mask != '0))
        else $error("run ended without tlast");

    // a frame that reacts leaves its reactions queued
    a_react_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (n_react != '0)) |=> (r_mask != '0))
        else $error("reactions of a frame were lost");

    // no frame is taken while reactions are still queued
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |-> (mask_after == '0))
        else $error("frame taken over pending reactions");

endmodule
